[rtl/tfe_pkg.sv]
// Shared types and constants for the tokamak field evaluator.
`timescale 1ns / 1ps
package tfe_pkg;

    // Fixed-point format of positions and fields
    localparam int FRAC_BITS = 16;
    localparam int POS_W     = 32;
    localparam int OUT_W     = 40;
    localparam int INNER_W   = 40;

    // Configuration register widths
    localparam int B0_W       = 21;
    localparam int R0_W       = 21;
    localparam int Q_W        = 20;
    localparam int A_W        = 19;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 21;

    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_FIELD    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAJOR_RADIUS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAFETY_FACTOR = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MINOR_RADIUS  = 2'd3;

    localparam logic [B0_W-1:0] AXIS_FIELD_RST    = 21'd327680;
    localparam logic [R0_W-1:0] MAJOR_RADIUS_RST  = 21'd393216;
    localparam logic [Q_W-1:0]  SAFETY_FACTOR_RST = 20'd131072;
    localparam logic [A_W-1:0]  MINOR_RADIUS_RST  = 19'd131072;

    // Smallest major radius used, 0.01 m rounded to nearest
    localparam int RMIN_INT = ((1 << FRAC_BITS) + 50) / 100;

    // Square root pipeline: 64-bit radicand, one root bit per stage
    localparam int SQ_IN_W  = 64;
    localparam int SQ_BITS  = 32;
    localparam int SQRT_LAT = SQ_BITS + 1;

    // Divider pipeline: one quotient bit per stage, overflow above DIV_QB bits
    localparam int DIV_NUM_W = 73;
    localparam int DIV_DEN_W = 52;
    localparam int DIV_QB    = 41;
    localparam int DIV_Q_W   = DIV_QB + 1;
    localparam int DIV_LAT   = DIV_QB + 2;

    localparam logic [INNER_W-1:0]       INNER_MAX = {INNER_W{1'b1}};
    localparam logic signed [OUT_W-1:0]  OUT_MAX   = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0]  OUT_MIN   = {1'b1, {(OUT_W-1){1'b0}}};

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
    } in_word_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] field_x;
        logic signed [OUT_W-1:0] field_y;
        logic signed [OUT_W-1:0] field_z;
        logic                    inside_plasma;
    } out_word_t;

    // Divider result word: rounded quotient magnitude and overflow
    typedef struct packed {
        logic               valid;
        logic               ovf;
        logic [DIV_Q_W-1:0] quo;
    } div_res_t;

endpackage

[rtl/tfe_sqrt_pipe.sv]
// Pipelined integer square root, one root bit resolved per stage.
`timescale 1ns / 1ps
module tfe_sqrt_pipe (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [tfe_pkg::SQ_IN_W-1:0]  radicand,
    output logic                         out_valid,
    output logic [tfe_pkg::SQ_BITS-1:0]  root
);
    import tfe_pkg::*;

    logic [SQRT_LAT-1:0] valid_reg;
    logic [SQ_IN_W-1:0]  rem_reg  [0:SQ_BITS];
    logic [SQ_BITS-1:0]  root_reg [0:SQ_BITS];
    logic [SQ_IN_W-1:0]  rem_next  [1:SQ_BITS];
    logic [SQ_BITS-1:0]  root_next [1:SQ_BITS];

    // Valid bits travel alongside the stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[SQRT_LAT-2:0], in_valid};
        end
    end

    // Each stage tries the next lower root bit against the remainder
    always_comb
    begin
        for (int k = 1; k <= SQ_BITS; k++)
        begin
            logic [SQ_IN_W-1:0] trial;
            trial = (SQ_IN_W'(root_reg[k-1]) << (SQ_BITS - k + 1))
                  | (SQ_IN_W'(1) << (2 * (SQ_BITS - k)));
            if (rem_reg[k-1] >= trial)
            begin
                rem_next[k]  = rem_reg[k-1] - trial;
                root_next[k] = root_reg[k-1] | (SQ_BITS'(1) << (SQ_BITS - k));
            end
            else
            begin
                rem_next[k]  = rem_reg[k-1];
                root_next[k] = root_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= radicand;
        root_reg[0] <= '0;
        for (int k = 1; k <= SQ_BITS; k++)
        begin
            rem_reg[k]  <= rem_next[k];
            root_reg[k] <= root_next[k];
        end
    end

    assign out_valid = valid_reg[SQRT_LAT-1];
    assign root      = root_reg[SQ_BITS];

endmodule

[rtl/tfe_div_pipe.sv]
// Pipelined restoring divider with round-half-up and quotient overflow flag.
`timescale 1ns / 1ps
module tfe_div_pipe (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic [tfe_pkg::DIV_NUM_W-1:0]  dividend,
    input  logic [tfe_pkg::DIV_DEN_W-1:0]  divisor,
    output tfe_pkg::div_res_t              res
);
    import tfe_pkg::*;

    logic [DIV_LAT-1:0]   valid_reg;
    logic [DIV_DEN_W-1:0] rem_reg [0:DIV_QB];
    logic [DIV_DEN_W-1:0] den_reg [0:DIV_QB];
    logic [DIV_QB-1:0]    quo_reg [0:DIV_QB];
    logic [DIV_QB-1:0]    low_reg [0:DIV_QB-1];
    logic                 ovf_reg [0:DIV_QB];
    logic [DIV_DEN_W-1:0] rem_next [1:DIV_QB];
    logic [DIV_QB-1:0]    quo_next [1:DIV_QB];
    logic [DIV_DEN_W-1:0] head;
    logic                 rnd;
    logic [DIV_Q_W-1:0]   quo_out_reg;
    logic                 ovf_out_reg;

    // Top dividend bits; if they already reach the divisor the quotient is too wide
    assign head = DIV_DEN_W'(dividend[DIV_NUM_W-1:DIV_QB]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[DIV_LAT-2:0], in_valid};
        end
    end

    // One quotient bit per stage
    always_comb
    begin
        for (int k = 1; k <= DIV_QB; k++)
        begin
            logic [DIV_DEN_W:0] shifted;
            shifted = {rem_reg[k-1], low_reg[k-1][DIV_QB-1]};
            if (shifted >= {1'b0, den_reg[k-1]})
            begin
                rem_next[k] = DIV_DEN_W'(shifted - {1'b0, den_reg[k-1]});
                quo_next[k] = {quo_reg[k-1][DIV_QB-2:0], 1'b1};
            end
            else
            begin
                rem_next[k] = shifted[DIV_DEN_W-1:0];
                quo_next[k] = {quo_reg[k-1][DIV_QB-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= head;
        den_reg[0] <= divisor;
        quo_reg[0] <= '0;
        low_reg[0] <= dividend[DIV_QB-1:0];
        ovf_reg[0] <= (head >= divisor);
        for (int k = 1; k <= DIV_QB; k++)
        begin
            rem_reg[k] <= rem_next[k];
            quo_reg[k] <= quo_next[k];
            den_reg[k] <= den_reg[k-1];
            ovf_reg[k] <= ovf_reg[k-1];
        end
        for (int k = 1; k < DIV_QB; k++)
        begin
            low_reg[k] <= low_reg[k-1] << 1;
        end
    end

    // Round to nearest, ties up: remainder at least half the divisor
    assign rnd = rem_reg[DIV_QB] >= (den_reg[DIV_QB] - rem_reg[DIV_QB]);

    always_ff @(posedge clk)
    begin
        quo_out_reg <= DIV_Q_W'(quo_reg[DIV_QB]) + DIV_Q_W'(rnd);
        ovf_out_reg <= ovf_reg[DIV_QB];
    end

    assign res.valid = valid_reg[DIV_LAT-1];
    assign res.ovf   = ovf_out_reg;
    assign res.quo   = quo_out_reg;

endmodule

[rtl/tokamak_field_evaluator_unit.sv]
// Top level of the tokamak magnetic field evaluator pipeline.
`timescale 1ns / 1ps
// Usage:
//   Input: drive in_data and raise start; a word is taken on every clock edge
//   with start high and busy low. busy is always low, so one position can be
//   issued every cycle.
//   Output: done is high for one cycle with result valid; the receiver cannot
//   stall, results must be captured in that cycle.
//   Configuration: cfg_valid/cfg_index/cfg_data write B0, R0, q, a; cfg_ready
//   is always high. Write only while no evaluation is in flight.
//   Pipeline: 1 input stage, 33 square root stages, 2 setup stages, 43 divider
//   stages, 5 rotation stages, 43 divider stages and 1 output stage, in order.
//   Throughput: one word per cycle; set by the bit-per-stage square root and
//   dividers, which are fully pipelined.
//   Reset: rst_n clears all valid bits and loads the register defaults
//   (B0 5.0 T, R0 6.0 m, q 2.0, a 2.0 m); nothing is in flight afterwards.
module tokamak_field_evaluator_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  tfe_pkg::in_word_t               in_data,
    output logic                            done,
    output tfe_pkg::out_word_t              result,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tfe_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tfe_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import tfe_pkg::*;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic [POS_W-1:0]        az;
        logic                    zpos;
    } pos_side_t;

    typedef struct packed {
        logic                    in_plasma;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic [SQ_BITS-1:0]      r;
        logic                    zpos;
        logic                    rneg;
    } pol_side_t;

    typedef struct packed {
        logic                    in_plasma;
        logic [SQ_BITS-1:0]      r;
        logic signed [OUT_W-1:0] fz;
    } rot_side_t;

    typedef struct packed {
        logic                    in_plasma;
        logic signed [OUT_W-1:0] fz;
        logic                    negx;
        logic                    negy;
    } fin_side_t;

    localparam int PH_W = 22;
    localparam int PL_W = 21;
    localparam int NUM_W = 74;

    // Rounded magnitude clipped to the inner range
    function automatic logic [INNER_W-1:0] clamp_inner(input div_res_t d);
        logic [INNER_W-1:0] v;
        if (d.ovf || d.quo > DIV_Q_W'(INNER_MAX))
            v = INNER_MAX;
        else
            v = d.quo[INNER_W-1:0];
        return v;
    endfunction

    // Apply sign to a magnitude and saturate to the output range
    function automatic logic signed [OUT_W-1:0] sat_out(input logic neg,
                                                        input logic [DIV_Q_W-1:0] mag,
                                                        input logic ovf);
        logic signed [OUT_W-1:0] v;
        if (neg)
        begin
            if (ovf || mag > DIV_Q_W'({1'b1, {(OUT_W-1){1'b0}}}))
                v = OUT_MIN;
            else
                v = OUT_W'(~mag[OUT_W-1:0] + 1'b1);
        end
        else
        begin
            if (ovf || mag > DIV_Q_W'(OUT_MAX))
                v = OUT_MAX;
            else
                v = mag[OUT_W-1:0];
        end
        return v;
    endfunction

    // Configuration registers
    logic [B0_W-1:0] b0_reg;
    logic [R0_W-1:0] r0_reg;
    logic [Q_W-1:0]  q_reg;
    logic [A_W-1:0]  a_reg;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_reg <= AXIS_FIELD_RST;
            r0_reg <= MAJOR_RADIUS_RST;
            q_reg  <= SAFETY_FACTOR_RST;
            a_reg  <= MINOR_RADIUS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_AXIS_FIELD:    b0_reg <= cfg_data[B0_W-1:0];
                CFG_MAJOR_RADIUS:  r0_reg <= cfg_data[R0_W-1:0];
                CFG_SAFETY_FACTOR: q_reg  <= cfg_data[Q_W-1:0];
                CFG_MINOR_RADIUS:  a_reg  <= cfg_data[A_W-1:0];
            endcase
        end
    end

    // Valid bits of the local stages
    logic valid_a_reg, valid_c_reg, valid_d_reg, valid_e_reg;
    logic valid_f_reg, valid_g_reg, valid_h_reg, valid_i_reg, done_reg;
    logic sq_valid;
    div_res_t res_br, res_bz, res_bp, res_fx, res_fy;

    // Stage a: magnitudes and squares of x and y
    logic [POS_W-1:0]   ax, ay, az;
    logic [SQ_IN_W-1:0] sqx_reg, sqy_reg;
    pos_side_t          side_a_reg;

    assign ax = in_data.pos_x[POS_W-1] ? (~in_data.pos_x + 1'b1) : in_data.pos_x;
    assign ay = in_data.pos_y[POS_W-1] ? (~in_data.pos_y + 1'b1) : in_data.pos_y;
    assign az = in_data.pos_z[POS_W-1] ? (~in_data.pos_z + 1'b1) : in_data.pos_z;

    always_ff @(posedge clk)
    begin
        sqx_reg         <= SQ_IN_W'(ax) * SQ_IN_W'(ax);
        sqy_reg         <= SQ_IN_W'(ay) * SQ_IN_W'(ay);
        side_a_reg.x    <= in_data.pos_x;
        side_a_reg.y    <= in_data.pos_y;
        side_a_reg.az   <= az;
        side_a_reg.zpos <= !in_data.pos_z[POS_W-1] && (in_data.pos_z != '0);
    end

    // Major radius by square root; position rides a matching delay line
    logic [SQ_BITS-1:0] sq_root;
    pos_side_t          pos_dly_reg [0:SQRT_LAT-1];

    tfe_sqrt_pipe u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (valid_a_reg),
        .radicand  (sqx_reg + sqy_reg),
        .out_valid (sq_valid),
        .root      (sq_root)
    );

    always_ff @(posedge clk)
    begin
        pos_dly_reg[0] <= side_a_reg;
        for (int k = 1; k < SQRT_LAT; k++)
        begin
            pos_dly_reg[k] <= pos_dly_reg[k-1];
        end
    end

    // Stage c: clamp R and form |R - R0|
    logic [SQ_BITS-1:0] r_clamp, r0_ext;
    logic [SQ_BITS-1:0] r_c_reg, ar_c_reg;
    logic               rneg_c_reg;
    pos_side_t          side_c_reg;

    assign r_clamp = (sq_root < SQ_BITS'(RMIN_INT)) ? SQ_BITS'(RMIN_INT) : sq_root;
    assign r0_ext  = SQ_BITS'(r0_reg);

    always_ff @(posedge clk)
    begin
        r_c_reg    <= r_clamp;
        rneg_c_reg <= r_clamp < r0_ext;
        ar_c_reg   <= (r_clamp < r0_ext) ? (r0_ext - r_clamp) : (r_clamp - r0_ext);
        side_c_reg <= pos_dly_reg[SQRT_LAT-1];
    end

    // Stage d: minor radius terms, numerators and poloidal denominator
    localparam int SQA_W = 2 * A_W;
    logic [Q_W-1:0]       q_eff;
    logic                 coarse_out_reg;
    logic [SQA_W-1:0]     sa_reg, sz_reg, asq_reg;
    logic [B0_W+A_W-1:0]  nbr_reg, nbz_reg;
    logic [B0_W+R0_W-1:0] nbp_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    pol_side_t            side_d;
    pos_side_t            side_d_reg;
    logic [SQ_BITS-1:0]   r_d_reg;
    logic                 rneg_d_reg;

    assign q_eff = (q_reg == '0) ? Q_W'(1) : q_reg;

    always_ff @(posedge clk)
    begin
        coarse_out_reg <= (ar_c_reg > SQ_BITS'(a_reg)) || (side_c_reg.az > POS_W'(a_reg));
        sa_reg   <= SQA_W'(ar_c_reg[A_W-1:0]) * SQA_W'(ar_c_reg[A_W-1:0]);
        sz_reg   <= SQA_W'(side_c_reg.az[A_W-1:0]) * SQA_W'(side_c_reg.az[A_W-1:0]);
        asq_reg  <= SQA_W'(a_reg) * SQA_W'(a_reg);
        nbr_reg  <= (B0_W+A_W)'(b0_reg) * (B0_W+A_W)'(side_c_reg.az[A_W-1:0]);
        nbz_reg  <= (B0_W+A_W)'(b0_reg) * (B0_W+A_W)'(ar_c_reg[A_W-1:0]);
        nbp_reg  <= (B0_W+R0_W)'(b0_reg) * (B0_W+R0_W)'(r0_reg);
        den_reg  <= DIV_DEN_W'(q_eff) * DIV_DEN_W'(r_c_reg);
        side_d_reg <= side_c_reg;
        r_d_reg    <= r_c_reg;
        rneg_d_reg <= rneg_c_reg;
    end

    // Inside test finishes as the items enter the dividers
    assign side_d.in_plasma = !coarse_out_reg
                            && ((SQA_W+1)'(sa_reg) + (SQA_W+1)'(sz_reg) <= (SQA_W+1)'(asq_reg));
    assign side_d.x    = side_d_reg.x;
    assign side_d.y    = side_d_reg.y;
    assign side_d.r    = r_d_reg;
    assign side_d.zpos = side_d_reg.zpos;
    assign side_d.rneg = rneg_d_reg;

    // Poloidal and toroidal divisions
    pol_side_t pol_dly_reg [0:DIV_LAT-1];

    tfe_div_pipe u_div_br (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (valid_d_reg),
        .dividend (DIV_NUM_W'({nbr_reg, {FRAC_BITS{1'b0}}})),
        .divisor  (den_reg),
        .res      (res_br)
    );

    tfe_div_pipe u_div_bz (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (valid_d_reg),
        .dividend (DIV_NUM_W'({nbz_reg, {FRAC_BITS{1'b0}}})),
        .divisor  (den_reg),
        .res      (res_bz)
    );

    tfe_div_pipe u_div_bp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (valid_d_reg),
        .dividend (DIV_NUM_W'(nbp_reg)),
        .divisor  (DIV_DEN_W'(r_d_reg)),
        .res      (res_bp)
    );

    always_ff @(posedge clk)
    begin
        pol_dly_reg[0] <= side_d;
        for (int k = 1; k < DIV_LAT; k++)
        begin
            pol_dly_reg[k] <= pol_dly_reg[k-1];
        end
    end

    // Stage e: clip, sign and saturate the cylindrical components
    pol_side_t               pol_out;
    logic [INNER_W-1:0]      br_mag;
    logic signed [PH_W+19:0] br_e_reg, bphi_e_reg;
    logic signed [POS_W-1:0] x_e_reg, y_e_reg;
    rot_side_t               side_e_reg;

    assign pol_out = pol_dly_reg[DIV_LAT-1];
    assign br_mag  = clamp_inner(res_br);

    always_ff @(posedge clk)
    begin
        br_e_reg   <= pol_out.zpos ? -$signed({2'b00, br_mag}) : $signed({2'b00, br_mag});
        bphi_e_reg <= $signed({2'b00, clamp_inner(res_bp)});
        x_e_reg    <= pol_out.x;
        y_e_reg    <= pol_out.y;
        side_e_reg.in_plasma <= pol_out.in_plasma;
        side_e_reg.r         <= pol_out.r;
        side_e_reg.fz        <= sat_out(pol_out.rneg, res_bz.quo, res_bz.ovf);
    end

    // Stage f: partial products, components split at bit 20
    localparam int PPH_W = PH_W + POS_W;
    localparam int PPL_W = PL_W + POS_W;
    logic signed [PH_W-1:0]  br_hi, bphi_hi;
    logic signed [PL_W-1:0]  br_lo, bphi_lo;
    logic signed [PPH_W-1:0] hbx_reg, hby_reg, hpx_reg, hpy_reg;
    logic signed [PPL_W-1:0] lbx_reg, lby_reg, lpx_reg, lpy_reg;
    rot_side_t               side_f_reg;

    assign br_hi   = br_e_reg[PH_W+19:20];
    assign br_lo   = $signed({1'b0, br_e_reg[19:0]});
    assign bphi_hi = bphi_e_reg[PH_W+19:20];
    assign bphi_lo = $signed({1'b0, bphi_e_reg[19:0]});

    always_ff @(posedge clk)
    begin
        hbx_reg <= PPH_W'(br_hi) * PPH_W'(x_e_reg);
        hby_reg <= PPH_W'(br_hi) * PPH_W'(y_e_reg);
        hpx_reg <= PPH_W'(bphi_hi) * PPH_W'(x_e_reg);
        hpy_reg <= PPH_W'(bphi_hi) * PPH_W'(y_e_reg);
        lbx_reg <= PPL_W'(br_lo) * PPL_W'(x_e_reg);
        lby_reg <= PPL_W'(br_lo) * PPL_W'(y_e_reg);
        lpx_reg <= PPL_W'(bphi_lo) * PPL_W'(x_e_reg);
        lpy_reg <= PPL_W'(bphi_lo) * PPL_W'(y_e_reg);
        side_f_reg <= side_e_reg;
    end

    // Stage g: recombine the partial products
    logic signed [NUM_W-1:0] pbx_reg, pby_reg, ppx_reg, ppy_reg;
    rot_side_t               side_g_reg;

    always_ff @(posedge clk)
    begin
        pbx_reg <= (NUM_W'(hbx_reg) <<< 20) + NUM_W'(lbx_reg);
        pby_reg <= (NUM_W'(hby_reg) <<< 20) + NUM_W'(lby_reg);
        ppx_reg <= (NUM_W'(hpx_reg) <<< 20) + NUM_W'(lpx_reg);
        ppy_reg <= (NUM_W'(hpy_reg) <<< 20) + NUM_W'(lpy_reg);
        side_g_reg <= side_f_reg;
    end

    // Stage h: rotation numerators
    logic signed [NUM_W-1:0] nx_reg, ny_reg;
    rot_side_t               side_h_reg;

    always_ff @(posedge clk)
    begin
        nx_reg <= pbx_reg - ppy_reg;
        ny_reg <= pby_reg + ppx_reg;
        side_h_reg <= side_g_reg;
    end

    // Stage i: sign and magnitude for the final divisions
    logic [DIV_NUM_W-1:0] magx_reg, magy_reg;
    fin_side_t            side_i_reg;
    logic [SQ_BITS-1:0]   r_i_reg;

    always_ff @(posedge clk)
    begin
        magx_reg <= DIV_NUM_W'(nx_reg[NUM_W-1] ? -nx_reg : nx_reg);
        magy_reg <= DIV_NUM_W'(ny_reg[NUM_W-1] ? -ny_reg : ny_reg);
        side_i_reg.in_plasma <= side_h_reg.in_plasma;
        side_i_reg.fz        <= side_h_reg.fz;
        side_i_reg.negx      <= nx_reg[NUM_W-1];
        side_i_reg.negy      <= ny_reg[NUM_W-1];
        r_i_reg <= side_h_reg.r;
    end

    // Division by R into Cartesian components
    fin_side_t fin_dly_reg [0:DIV_LAT-1];
    fin_side_t fin_out;

    tfe_div_pipe u_div_fx (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (valid_i_reg),
        .dividend (magx_reg),
        .divisor  (DIV_DEN_W'(r_i_reg)),
        .res      (res_fx)
    );

    tfe_div_pipe u_div_fy (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (valid_i_reg),
        .dividend (magy_reg),
        .divisor  (DIV_DEN_W'(r_i_reg)),
        .res      (res_fy)
    );

    always_ff @(posedge clk)
    begin
        fin_dly_reg[0] <= side_i_reg;
        for (int k = 1; k < DIV_LAT; k++)
        begin
            fin_dly_reg[k] <= fin_dly_reg[k-1];
        end
    end

    assign fin_out = fin_dly_reg[DIV_LAT-1];

    // Output register: zero field outside the plasma
    out_word_t result_reg;

    always_ff @(posedge clk)
    begin
        if (fin_out.in_plasma)
        begin
            result_reg.field_x       <= sat_out(fin_out.negx, res_fx.quo, res_fx.ovf);
            result_reg.field_y       <= sat_out(fin_out.negy, res_fy.quo, res_fy.ovf);
            result_reg.field_z       <= fin_out.fz;
            result_reg.inside_plasma <= 1'b1;
        end
        else
        begin
            result_reg <= '0;
        end
    end

    // Valid bits of the local stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_c_reg <= 1'b0;
            valid_d_reg <= 1'b0;
            valid_e_reg <= 1'b0;
            valid_f_reg <= 1'b0;
            valid_g_reg <= 1'b0;
            valid_h_reg <= 1'b0;
            valid_i_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            valid_a_reg <= start && !busy;
            valid_c_reg <= sq_valid;
            valid_d_reg <= valid_c_reg;
            valid_e_reg <= res_br.valid;
            valid_f_reg <= valid_e_reg;
            valid_g_reg <= valid_f_reg;
            valid_h_reg <= valid_g_reg;
            valid_i_reg <= valid_h_reg;
            done_reg    <= res_fx.valid && res_fy.valid;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

[tb/tokamak_field_evaluator_unit_tb.sv]
// Testbench for the tokamak field evaluator: predicts each field word and checks it.
`timescale 1ns / 1ps
module tokamak_field_evaluator_unit_tb;
    import tfe_pkg::*;

    localparam int  RUN_LIMIT = 400000;
    localparam int  DRAIN_GAP = 140;
    localparam longint unsigned RMIN = 64'd655;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    in_word_t   in_data;
    logic       done;
    out_word_t  result;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Predictor copy of the register file
    longint unsigned b0_reg, r0_reg, q_reg, a_reg;

    out_word_t field_queue[$];
    int        mismatches;
    int        idle_pct;
    int        cycle_count;

    tokamak_field_evaluator_unit u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
        .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Floor square root, bit by bit
    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'h1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    // Division rounded to nearest, ties away from zero
    function automatic longint unsigned div_near(longint unsigned n, longint unsigned d);
        longint unsigned qq;
        longint unsigned rr;
        qq = n / d;
        rr = n % d;
        if (rr >= d - rr)
            qq = qq + 1;
        return qq;
    endfunction

    function automatic logic signed [127:0] sdiv_near(logic signed [127:0] n,
                                                      longint unsigned d);
        logic [127:0] m;
        logic [127:0] qq;
        logic [127:0] rr;
        m = (n < 0) ? -n : n;
        qq = m / d;
        rr = m % d;
        if (rr >= d - rr)
            qq = qq + 1;
        return (n < 0) ? -$signed(qq) : $signed(qq);
    endfunction

    function automatic logic signed [OUT_W-1:0] clip40(logic signed [127:0] v);
        if (v > 128'sd549755813887)
            return OUT_MAX;
        if (v < -128'sd549755813888)
            return OUT_MIN;
        return v[OUT_W-1:0];
    endfunction

    function automatic longint unsigned clip_inner(longint unsigned v);
        return (v > 64'hFF_FFFF_FFFF) ? 64'hFF_FFFF_FFFF : v;
    endfunction

    // Expected field word for one position under the current registers
    function automatic out_word_t field_at(in_word_t p);
        out_word_t o;
        longint signed x, y, z, rrel, br, bz, bphi;
        longint unsigned ax, ay, az, rad, ar, den, qv;
        x = p.pos_x;
        y = p.pos_y;
        z = p.pos_z;
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        az = (z < 0) ? -z : z;
        rad = root_floor(ax * ax + ay * ay);
        if (rad < RMIN)
            rad = RMIN;
        rrel = longint'(rad) - longint'(r0_reg);
        ar = (rrel < 0) ? -rrel : rrel;
        o = '0;
        if (ar > a_reg || az > a_reg || ar * ar + az * az > a_reg * a_reg)
            return o;
        qv = (q_reg != 0) ? q_reg : 64'd1;
        den = qv * rad;
        br = clip_inner(div_near((b0_reg * az) << FRAC_BITS, den));
        if (z > 0)
            br = -br;
        bz = clip_inner(div_near((b0_reg * ar) << FRAC_BITS, den));
        if (rrel < 0)
            bz = -bz;
        bphi = clip_inner(div_near(b0_reg * r0_reg, rad));
        o.field_x = clip40(sdiv_near(128'(br) * 128'(x) - 128'(bphi) * 128'(y), rad));
        o.field_y = clip40(sdiv_near(128'(br) * 128'(y) + 128'(bphi) * 128'(x), rad));
        o.field_z = clip40(128'(bz));
        o.inside_plasma = 1'b1;
        return o;
    endfunction

    // Send one word, first with a random idle gap in idle_pct percent of calls
    task automatic send_word(in_word_t w);
        int gap;
        if ($urandom_range(99) < idle_pct)
        begin
            gap = $urandom_range(1, 4);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        in_data <= w;
        do @(posedge clk); while (busy);
        field_queue.push_back(field_at(w));
    endtask

    // Let every expected word come back, then the pipeline empty
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (field_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_GAP) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_AXIS_FIELD:    b0_reg = val & 21'h1FFFFF;
            CFG_MAJOR_RADIUS:  r0_reg = val & 21'h1FFFFF;
            CFG_SAFETY_FACTOR: q_reg  = val & 20'hFFFFF;
            CFG_MINOR_RADIUS:  a_reg  = val & 19'h7FFFF;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_regs(int b0, int r0, int qf, int am);
        drain();
        write_reg(CFG_AXIS_FIELD, b0);
        write_reg(CFG_MAJOR_RADIUS, r0);
        write_reg(CFG_SAFETY_FACTOR, qf);
        write_reg(CFG_MINOR_RADIUS, am);
    endtask

    function automatic in_word_t pos_word(int x, int y, int z);
        in_word_t w;
        w.pos_x = x;
        w.pos_y = y;
        w.pos_z = z;
        return w;
    endfunction

    // Point on a random flux surface near the axis, mostly inside
    function automatic in_word_t plasma_point();
        longint signed rr, xx, yy, zz, span;
        span = longint'(a_reg) + 64;
        rr = longint'(r0_reg) + longint'($urandom_range(0, 2 * span)) - span;
        if (rr < 1)
            rr = 1;
        zz = longint'($urandom_range(0, 2 * span)) - span;
        xx = longint'($urandom_range(0, 2 * rr)) - rr;
        yy = root_floor(rr * rr - xx * xx);
        if ($urandom_range(1))
            yy = -yy;
        return pos_word(xx, yy, zz);
    endfunction

    task automatic random_words(int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < 80)
                send_word(plasma_point());
            else
                send_word(pos_word($urandom, $urandom, $urandom));
        end
    endtask

    // Edges of the input range, axis, clamp and boundary points
    task automatic test_directed();
        send_word(pos_word(0, 0, 0));
        send_word(pos_word(393216, 0, 0));
        send_word(pos_word(0, -393216, 0));
        send_word(pos_word(393216 + 131072, 0, 0));
        send_word(pos_word(393216 + 131073, 0, 0));
        send_word(pos_word(393216, 0, 131072));
        send_word(pos_word(393216, 0, -131072));
        send_word(pos_word(393216, 0, 131073));
        send_word(pos_word(-393216, 0, -65536));
        send_word(pos_word(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
        send_word(pos_word(32'h80000000, 32'h80000000, 32'h80000000));
        send_word(pos_word(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF));
        send_word(pos_word(300000, 200000, -100000));
        send_word(pos_word(-280000, 290000, 70000));
    endtask

    // Extreme registers: small radius with clamp active and a zero safety factor, all ones, zero B0 and R0, large R0
    task automatic test_extreme_regs();
        set_regs(1310720, 65536, 0, 65536);
        send_word(pos_word(0, 0, 0));
        send_word(pos_word(100, 0, 0));
        random_words(60);
        set_regs(21'h1FFFFF, 21'h1FFFFF, 21'h1FFFFF, 21'h1FFFFF);
        random_words(80);
        set_regs(6554, 1310720, 655360, 327680);
        random_words(80);
        set_regs(0, 0, 32768, 6554);
        send_word(pos_word(0, 0, 0));
        random_words(30);
        set_regs(1310720, 1310720, 32768, 327680);
        random_words(100);
    endtask

    task automatic test_random_phases();
        int pct[3] = '{0, 69, 22};
        for (int ph = 0; ph < 3; ph++)
        begin
            set_regs($urandom_range(6554, 1310720), $urandom_range(65536, 1310720),
                     $urandom_range(32768, 655360), $urandom_range(6554, 327680));
            idle_pct = pct[ph];
            random_words(320);
        end
        idle_pct = 30;
    endtask

    // Compare each field word against the oldest expectation
    always @(posedge clk)
    begin
        out_word_t exp_w;
        if (rst_n && done)
        begin
            if (field_queue.size() == 0)
            begin
                $display("%0t: unexpected word %h", $time, result);
                mismatches++;
            end
            else
            begin
                exp_w = field_queue.pop_front();
                if (result.field_x !== exp_w.field_x)
                begin
                    $display("%0t: field_x expected %h actual %h", $time,
                             exp_w.field_x, result.field_x);
                    mismatches++;
                end
                if (result.field_y !== exp_w.field_y)
                begin
                    $display("%0t: field_y expected %h actual %h", $time,
                             exp_w.field_y, result.field_y);
                    mismatches++;
                end
                if (result.field_z !== exp_w.field_z)
                begin
                    $display("%0t: field_z expected %h actual %h", $time,
                             exp_w.field_z, result.field_z);
                    mismatches++;
                end
                if (result.inside_plasma !== exp_w.inside_plasma)
                begin
                    $display("%0t: inside_plasma expected %b actual %b", $time,
                             exp_w.inside_plasma, result.inside_plasma);
                    mismatches++;
                end
            end
        end
    end

    // Run guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > RUN_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        cycle_count = 0;
        mismatches  = 0;
        idle_pct    = 0;
        rst_n     = 1'b0;
        start     = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_AXIS_FIELD;
        cfg_data  = '0;
        b0_reg = AXIS_FIELD_RST;
        r0_reg = MAJOR_RADIUS_RST;
        q_reg  = SAFETY_FACTOR_RST;
        a_reg  = MINOR_RADIUS_RST;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_extreme_regs();
        test_random_phases();
        set_regs(327680, 393216, 131072, 131072);
        random_words(100);
        drain();

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
